// File: rtl/core/ftic_pkg.sv
// Shared types and constants for the fuzzy term inclusion/coverage block.
`timescale 1ns / 1ps
`default_nettype none

package ftic_pkg;

  localparam int FRAC_BITS = 15;
  localparam int VAL_W     = 16;
  localparam int ACC_W     = 26;
  localparam int LVL_W     = 4;
  localparam int MAX_COLS  = 8;
  localparam int COL_IDX_W = 3;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int STEP_W    = $clog2(Q_W);
  localparam int NUM_RATIO = 6;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [VAL_W-1:0] ONE     = VAL_W'(1) << FRAC_BITS;
  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TERM_LEVELS   = 2'd0,
    CFG_FUZZY_COLUMNS = 2'd1,
    CFG_NECESSITY     = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    R_INCL_MIN = 3'd0,
    R_COV_MIN  = 3'd1,
    R_INCL_MAX = 3'd2,
    R_COV_MAX  = 3'd3,
    R_PRI_MIN  = 3'd4,
    R_PRI_MAX  = 3'd5
  } ratio_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COL,
    S_ACC,
    S_DSET,
    S_DCHK,
    S_DIV,
    S_OUT
  } ftic_state_t;

  typedef struct packed {
    logic [VAL_W-1:0] case_value_0;
    logic [VAL_W-1:0] case_value_1;
    logic [VAL_W-1:0] case_value_2;
    logic [VAL_W-1:0] case_value_3;
    logic [VAL_W-1:0] case_value_4;
    logic [VAL_W-1:0] case_value_5;
    logic [VAL_W-1:0] case_value_6;
    logic [VAL_W-1:0] case_value_7;
    logic [VAL_W-1:0] outcome_membership;
    logic             last_case;
  } ftic_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] inclusion_of_min;
    logic [VAL_W-1:0] coverage_of_min;
    logic [VAL_W-1:0] inclusion_of_max;
    logic [VAL_W-1:0] coverage_of_max;
    logic [VAL_W-1:0] pri_of_min;
    logic [VAL_W-1:0] pri_of_max;
    logic             empty_term;
  } ftic_out_t;

endpackage

`default_nettype wire

// File: rtl/core/fuzzy_term_inclusion_coverage.sv
// Fuzzy term inclusion, coverage and PRI accumulator with a serial ratio divider.
`timescale 1ns / 1ps
`default_nettype none

// Takes one case per request for one configured term (term_levels, fuzzy_columns,
// necessity_mode) and keeps seven saturating 26-bit sums. A small sequencer walks
// the term columns one per cycle through a shared adjust/min/max unit, so an
// ordinary case occupies the block from accept through its column states and the
// accumulate state back to idle, where the next case is accepted. A case flagged
// last_case then runs the six ratios through one shared restoring divider: a
// setup state and a check state, then 16 quotient-bit steps per ratio, which are
// skipped when a ratio is 0/0, x/0 or at least 2.0, before the result request is
// loaded. An empty term skips the divider entirely. The
// result sits in an output register, so new cases are taken while it waits.
// Ratios are truncated Q1.15, 0 for 0/0, clamped at 1.0; sums clear once the
// result is loaded. Write configuration only while the block is idle.
module fuzzy_term_inclusion_coverage #(
  parameter int COLUMNS = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output      logic                                  in_stall,
  input  wire ftic_pkg::ftic_in_t                    in_data,
  output      logic                                  out_valid,
  input  wire logic                                  out_stall,
  output      ftic_pkg::ftic_out_t                   out_data,
  input  wire logic                                  cfg_we,
  input  wire logic [ftic_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [ftic_pkg::CFG_W-1:0]            cfg_wdata
);

  localparam int VW = ftic_pkg::VAL_W;
  localparam int AW = ftic_pkg::ACC_W;
  localparam int QW = ftic_pkg::Q_W;
  localparam int SW = ftic_pkg::STEP_W;
  localparam int CW = ftic_pkg::COL_IDX_W;
  localparam int LW = ftic_pkg::LVL_W;

  function automatic logic [AW-1:0] sat_add(input logic [AW-1:0] a,
                                            input logic [VW-1:0] v);
    logic [AW:0] s;
    s = {1'b0, a} + (AW+1)'(v);
    return s[AW] ? ftic_pkg::ACC_MAX : s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] sub0(input logic [AW-1:0] a,
                                         input logic [AW-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  function automatic logic [VW-1:0] min2(input logic [VW-1:0] a,
                                         input logic [VW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // configuration
  logic [ftic_pkg::CFG_W-1:0]       levels_r;
  logic [ftic_pkg::MAX_COLS-1:0]    fuzzy_r;
  logic                             nec_r;

  // sequencer and datapath registers
  ftic_pkg::ftic_state_t  state_r, state_nxt;
  ftic_pkg::ftic_in_t     in_r, in_nxt;
  logic [CW-1:0]          col_r, col_nxt;
  logic                   any_r, any_nxt;
  logic [VW-1:0]          tmin_r, tmin_nxt;
  logic [VW-1:0]          tmax_r, tmax_nxt;
  logic [AW-1:0]          s_tmin_r, s_tmin_nxt;
  logic [AW-1:0]          s_tmax_r, s_tmax_nxt;
  logic [AW-1:0]          s_omin_r, s_omin_nxt;
  logic [AW-1:0]          s_omax_r, s_omax_nxt;
  logic [AW-1:0]          s_pmin_r, s_pmin_nxt;
  logic [AW-1:0]          s_pmax_r, s_pmax_nxt;
  logic [AW-1:0]          s_out_r, s_out_nxt;
  ftic_pkg::ratio_sel_t   ridx_r, ridx_nxt;
  logic [AW-1:0]          num_r, num_nxt;
  logic [AW-1:0]          den_r, den_nxt;
  logic [AW:0]            rem_r, rem_nxt;
  logic [QW-1:0]          q_r, q_nxt;
  logic [SW-1:0]          step_r, step_nxt;
  logic [VW-1:0]          res_r [ftic_pkg::NUM_RATIO];
  logic [VW-1:0]          res_nxt [ftic_pkg::NUM_RATIO];
  ftic_pkg::ftic_out_t    out_r, out_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // combinational helpers
  logic [VW-1:0]          vals [ftic_pkg::MAX_COLS];
  logic [LW-1:0]          lvl;
  logic [VW-1:0]          vraw;
  logic [VW-1:0]          vclip;
  logic [VW-1:0]          adj;
  logic [VW-1:0]          tmin_e, tmax_e, om, ovl_min, ovl_max, t2, pmin, pmax;
  logic [AW-1:0]          sel_num, sel_den;
  logic [AW:0]            rem_diff;
  logic                   ge;
  logic [QW-1:0]          q_fin;
  logic [VW-1:0]          q_sat;
  logic                   last_ratio;

  always_comb begin
    vals[0] = in_r.case_value_0;
    vals[1] = in_r.case_value_1;
    vals[2] = in_r.case_value_2;
    vals[3] = in_r.case_value_3;
    vals[4] = in_r.case_value_4;
    vals[5] = in_r.case_value_5;
    vals[6] = in_r.case_value_6;
    vals[7] = in_r.case_value_7;
  end

  // column adjust unit, one column per cycle
  always_comb begin
    lvl   = levels_r[col_r*LW +: LW];
    vraw  = vals[col_r];
    vclip = min2(vraw, ftic_pkg::ONE);
    if (fuzzy_r[col_r]) begin
      adj = (lvl == LW'(1)) ? (ftic_pkg::ONE - vclip) : vclip;
    end else begin
      adj = (((VW+1)'(vraw) + (VW+1)'(1)) == (VW+1)'(lvl)) ? ftic_pkg::ONE : '0;
    end
  end

  // per-case overlap terms
  always_comb begin
    tmin_e  = any_r ? tmin_r : '0;
    tmax_e  = any_r ? tmax_r : '0;
    om      = min2(in_r.outcome_membership, ftic_pkg::ONE);
    ovl_min = min2(tmin_e, om);
    ovl_max = min2(tmax_e, om);
    t2      = nec_r ? (ftic_pkg::ONE - tmin_e) : (ftic_pkg::ONE - om);
    pmin    = min2(ovl_min, t2);
    pmax    = min2(ovl_max, ftic_pkg::ONE - tmax_e);
  end

  // numerator / denominator pick for the current ratio
  always_comb begin
    unique case (ridx_r)
      ftic_pkg::R_INCL_MIN: begin
        sel_num = s_omin_r;
        sel_den = s_tmin_r;
      end
      ftic_pkg::R_COV_MIN: begin
        sel_num = s_omin_r;
        sel_den = s_out_r;
      end
      ftic_pkg::R_INCL_MAX: begin
        sel_num = s_omax_r;
        sel_den = s_tmax_r;
      end
      ftic_pkg::R_COV_MAX: begin
        sel_num = s_omax_r;
        sel_den = s_out_r;
      end
      ftic_pkg::R_PRI_MIN: begin
        sel_num = sub0(s_omin_r, s_pmin_r);
        sel_den = sub0(nec_r ? s_out_r : s_tmin_r, s_pmin_r);
      end
      ftic_pkg::R_PRI_MAX: begin
        sel_num = sub0(s_omax_r, s_pmax_r);
        sel_den = sub0(s_out_r, s_pmax_r);
      end
      default: begin
        sel_num = '0;
        sel_den = '0;
      end
    endcase
  end

  // restoring divider step
  always_comb begin
    rem_diff   = rem_r - {1'b0, den_r};
    ge         = (rem_r >= {1'b0, den_r});
    q_fin      = {q_r[QW-2:0], ge};
    q_sat      = (q_fin > QW'(ftic_pkg::ONE)) ? ftic_pkg::ONE : VW'(q_fin);
    last_ratio = (ridx_r == ftic_pkg::R_PRI_MAX);
  end

  assign in_stall  = (state_r != ftic_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    col_nxt       = col_r;
    any_nxt       = any_r;
    tmin_nxt      = tmin_r;
    tmax_nxt      = tmax_r;
    s_tmin_nxt    = s_tmin_r;
    s_tmax_nxt    = s_tmax_r;
    s_omin_nxt    = s_omin_r;
    s_omax_nxt    = s_omax_r;
    s_pmin_nxt    = s_pmin_r;
    s_pmax_nxt    = s_pmax_r;
    s_out_nxt     = s_out_r;
    ridx_nxt      = ridx_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    step_nxt      = step_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ftic_pkg::S_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          col_nxt   = '0;
          any_nxt   = 1'b0;
          state_nxt = ftic_pkg::S_COL;
        end
      end

      ftic_pkg::S_COL: begin
        if (lvl != '0) begin
          if (!any_r || adj < tmin_r) tmin_nxt = adj;
          if (!any_r || adj > tmax_r) tmax_nxt = adj;
          any_nxt = 1'b1;
        end
        if (col_r == CW'(COLUMNS - 1)) begin
          state_nxt = ftic_pkg::S_ACC;
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end

      ftic_pkg::S_ACC: begin
        s_tmin_nxt = sat_add(s_tmin_r, tmin_e);
        s_tmax_nxt = sat_add(s_tmax_r, tmax_e);
        s_omin_nxt = sat_add(s_omin_r, ovl_min);
        s_omax_nxt = sat_add(s_omax_r, ovl_max);
        s_pmin_nxt = sat_add(s_pmin_r, pmin);
        s_pmax_nxt = sat_add(s_pmax_r, pmax);
        s_out_nxt  = sat_add(s_out_r, om);
        if (!in_r.last_case) begin
          state_nxt = ftic_pkg::S_IDLE;
        end else if (any_r) begin
          ridx_nxt  = ftic_pkg::R_INCL_MIN;
          state_nxt = ftic_pkg::S_DSET;
        end else begin
          state_nxt = ftic_pkg::S_OUT;
        end
      end

      ftic_pkg::S_DSET: begin
        num_nxt   = sel_num;
        den_nxt   = sel_den;
        state_nxt = ftic_pkg::S_DCHK;
      end

      ftic_pkg::S_DCHK: begin
        // zero over zero, divide by zero and quotient >= 2.0 never need the divider
        priority if (num_r == '0 && den_r == '0) begin
          res_nxt[ridx_r] = '0;
        end else if (den_r == '0 || {1'b0, num_r} >= {den_r, 1'b0}) begin
          res_nxt[ridx_r] = ftic_pkg::ONE;
        end else begin
          rem_nxt  = {1'b0, num_r};
          q_nxt    = '0;
          step_nxt = SW'(QW - 1);
        end
        if ((num_r == '0 && den_r == '0) || den_r == '0 ||
            {1'b0, num_r} >= {den_r, 1'b0}) begin
          if (last_ratio) begin
            state_nxt = ftic_pkg::S_OUT;
          end else begin
            ridx_nxt  = ftic_pkg::ratio_sel_t'(ridx_r + 3'd1);
            state_nxt = ftic_pkg::S_DSET;
          end
        end else begin
          state_nxt = ftic_pkg::S_DIV;
        end
      end

      ftic_pkg::S_DIV: begin
        q_nxt   = q_fin;
        rem_nxt = (ge ? rem_diff : rem_r) << 1;
        if (step_r == '0) begin
          res_nxt[ridx_r] = q_sat;
          if (last_ratio) begin
            state_nxt = ftic_pkg::S_OUT;
          end else begin
            ridx_nxt  = ftic_pkg::ratio_sel_t'(ridx_r + 3'd1);
            state_nxt = ftic_pkg::S_DSET;
          end
        end else begin
          step_nxt = step_r - SW'(1);
        end
      end

      ftic_pkg::S_OUT: begin
        // wait for the output register to free up, then load and clear sums
        if (!out_valid_r || !out_stall) begin
          out_nxt.inclusion_of_min = any_r ? res_r[ftic_pkg::R_INCL_MIN] : '0;
          out_nxt.coverage_of_min  = any_r ? res_r[ftic_pkg::R_COV_MIN]  : '0;
          out_nxt.inclusion_of_max = any_r ? res_r[ftic_pkg::R_INCL_MAX] : '0;
          out_nxt.coverage_of_max  = any_r ? res_r[ftic_pkg::R_COV_MAX]  : '0;
          out_nxt.pri_of_min       = any_r ? res_r[ftic_pkg::R_PRI_MIN]  : '0;
          out_nxt.pri_of_max       = any_r ? res_r[ftic_pkg::R_PRI_MAX]  : '0;
          out_nxt.empty_term       = !any_r;
          out_valid_nxt            = 1'b1;
          s_tmin_nxt               = '0;
          s_tmax_nxt               = '0;
          s_omin_nxt               = '0;
          s_omax_nxt               = '0;
          s_pmin_nxt               = '0;
          s_pmax_nxt               = '0;
          s_out_nxt                = '0;
          state_nxt                = ftic_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ftic_pkg::S_IDLE;
      end
    endcase
  end

  // control state and sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ftic_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      s_tmin_r    <= '0;
      s_tmax_r    <= '0;
      s_omin_r    <= '0;
      s_omax_r    <= '0;
      s_pmin_r    <= '0;
      s_pmax_r    <= '0;
      s_out_r     <= '0;
      levels_r    <= '0;
      fuzzy_r     <= '0;
      nec_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      s_tmin_r    <= s_tmin_nxt;
      s_tmax_r    <= s_tmax_nxt;
      s_omin_r    <= s_omin_nxt;
      s_omax_r    <= s_omax_nxt;
      s_pmin_r    <= s_pmin_nxt;
      s_pmax_r    <= s_pmax_nxt;
      s_out_r     <= s_out_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ftic_pkg::CFG_TERM_LEVELS:   levels_r <= cfg_wdata;
          ftic_pkg::CFG_FUZZY_COLUMNS: fuzzy_r  <= cfg_wdata[ftic_pkg::MAX_COLS-1:0];
          ftic_pkg::CFG_NECESSITY:     nec_r    <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    in_r   <= in_nxt;
    col_r  <= col_nxt;
    any_r  <= any_nxt;
    tmin_r <= tmin_nxt;
    tmax_r <= tmax_nxt;
    ridx_r <= ridx_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

endmodule

`default_nettype wire

// File: verif/tb_fuzzy_term_inclusion_coverage.sv
// Self-checking testbench for the fuzzy term inclusion, coverage and PRI block.
`timescale 1ns / 1ps

module tb_fuzzy_term_inclusion_coverage;

  // Worst-case quiet time after the last result: six serial divisions,
  // plus one column walk, plus margin.
  localparam int DRAIN_CYCLES = 6 * 18 + ftic_pkg::MAX_COLS + 40;
  localparam int RUN_LIMIT_NS = 2_000_000;
  // Index 3 is not decoded by the block; writes to it must be dropped.
  localparam logic [ftic_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  ftic_pkg::ftic_in_t             in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  ftic_pkg::ftic_out_t            out_data;
  logic                           cfg_we    = 1'b0;
  logic [ftic_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ftic_pkg::CFG_W-1:0]     cfg_wdata = '0;

  // Idle rates of the two sides, in percent of cycles.
  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int mismatches      = 0;

  // Shadow copy of the configuration registers.
  logic [ftic_pkg::CFG_W-1:0]    cur_levels    = '0;
  logic [ftic_pkg::MAX_COLS-1:0] cur_fuzzy     = '0;
  logic                          cur_necessity = 1'b0;

  // Shadow copy of the seven running sums.
  logic [ftic_pkg::ACC_W-1:0] sum_tmin    = '0;
  logic [ftic_pkg::ACC_W-1:0] sum_tmax    = '0;
  logic [ftic_pkg::ACC_W-1:0] sum_ovl_min = '0;
  logic [ftic_pkg::ACC_W-1:0] sum_ovl_max = '0;
  logic [ftic_pkg::ACC_W-1:0] sum_pri_min = '0;
  logic [ftic_pkg::ACC_W-1:0] sum_pri_max = '0;
  logic [ftic_pkg::ACC_W-1:0] sum_out     = '0;

  // Ratios predicted for each last-case request, oldest first.
  ftic_pkg::ftic_out_t expected_ratios[$];
  ftic_pkg::ftic_out_t want;

  fuzzy_term_inclusion_coverage u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [ftic_pkg::VAL_W-1:0] min16(input logic [ftic_pkg::VAL_W-1:0] a,
                                                       input logic [ftic_pkg::VAL_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // Accumulators stick at all ones instead of wrapping.
  function automatic logic [ftic_pkg::ACC_W-1:0] sat_acc(
      input logic [ftic_pkg::ACC_W-1:0] acc,
      input logic [ftic_pkg::VAL_W-1:0] v);
    logic [ftic_pkg::ACC_W:0] s;
    s = {1'b0, acc} + (ftic_pkg::ACC_W+1)'(v);
    return s[ftic_pkg::ACC_W] ? ftic_pkg::ACC_MAX : s[ftic_pkg::ACC_W-1:0];
  endfunction

  function automatic logic [ftic_pkg::ACC_W-1:0] sub_floor(
      input logic [ftic_pkg::ACC_W-1:0] a,
      input logic [ftic_pkg::ACC_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  // Truncating Q1.15 quotient: 0/0 gives 0, x/0 and anything above 1.0 clamp.
  function automatic logic [ftic_pkg::VAL_W-1:0] q15_ratio(
      input logic [ftic_pkg::ACC_W-1:0] num,
      input logic [ftic_pkg::ACC_W-1:0] den);
    logic [ftic_pkg::ACC_W+ftic_pkg::FRAC_BITS-1:0] q;
    if (num == '0 && den == '0) return '0;
    if (den == '0) return ftic_pkg::ONE;
    q = {num, {ftic_pkg::FRAC_BITS{1'b0}}} / den;
    return (q > ftic_pkg::ONE) ? ftic_pkg::ONE : q[ftic_pkg::VAL_W-1:0];
  endfunction

  // Folds one case into the shadow sums; on a last case it yields the ratios
  // the block should report and clears the sums.
  task automatic accumulate_case(input ftic_pkg::ftic_in_t c, output bit done,
                                 output ftic_pkg::ftic_out_t r);
    logic [ftic_pkg::VAL_W-1:0] vals [ftic_pkg::MAX_COLS];
    logic [ftic_pkg::VAL_W-1:0] v, tmin, tmax, om, ovl_min, ovl_max, pri_cap;
    logic [ftic_pkg::LVL_W-1:0] lvl;
    bit                         any_col;
    vals = '{c.case_value_0, c.case_value_1, c.case_value_2, c.case_value_3,
             c.case_value_4, c.case_value_5, c.case_value_6, c.case_value_7};
    tmin    = ftic_pkg::ONE;
    tmax    = '0;
    any_col = 1'b0;
    for (int j = 0; j < ftic_pkg::MAX_COLS; j++) begin
      lvl = cur_levels[ftic_pkg::LVL_W*j +: ftic_pkg::LVL_W];
      if (lvl != '0) begin
        if (cur_fuzzy[j]) begin
          v = min16(vals[j], ftic_pkg::ONE);
          if (lvl == 1) v = ftic_pkg::ONE - v;   // level 1 means the negated membership
        end else begin
          // crisp: category value k matches level k + 1
          v = (32'(vals[j]) + 1 == 32'(lvl)) ? ftic_pkg::ONE : '0;
        end
        if (!any_col || v < tmin) tmin = v;
        if (!any_col || v > tmax) tmax = v;
        any_col = 1'b1;
      end
    end
    if (!any_col) begin
      tmin = '0;
      tmax = '0;
    end

    om      = min16(c.outcome_membership, ftic_pkg::ONE);
    ovl_min = min16(tmin, om);
    ovl_max = min16(tmax, om);
    pri_cap = cur_necessity ? ftic_pkg::ONE - tmin : ftic_pkg::ONE - om;

    sum_tmin    = sat_acc(sum_tmin, tmin);
    sum_tmax    = sat_acc(sum_tmax, tmax);
    sum_ovl_min = sat_acc(sum_ovl_min, ovl_min);
    sum_ovl_max = sat_acc(sum_ovl_max, ovl_max);
    sum_pri_min = sat_acc(sum_pri_min, min16(ovl_min, pri_cap));
    sum_pri_max = sat_acc(sum_pri_max, min16(ovl_max, ftic_pkg::ONE - tmax));
    sum_out     = sat_acc(sum_out, om);

    done = c.last_case;
    r    = '0;
    if (c.last_case) begin
      if (!any_col) begin
        r.empty_term = 1'b1;
      end else begin
        r.inclusion_of_min = q15_ratio(sum_ovl_min, sum_tmin);
        r.coverage_of_min  = q15_ratio(sum_ovl_min, sum_out);
        r.inclusion_of_max = q15_ratio(sum_ovl_max, sum_tmax);
        r.coverage_of_max  = q15_ratio(sum_ovl_max, sum_out);
        r.pri_of_min = q15_ratio(sub_floor(sum_ovl_min, sum_pri_min),
                                 sub_floor(cur_necessity ? sum_out : sum_tmin, sum_pri_min));
        r.pri_of_max = q15_ratio(sub_floor(sum_ovl_max, sum_pri_max),
                                 sub_floor(sum_out, sum_pri_max));
      end
      sum_tmin    = '0;
      sum_tmax    = '0;
      sum_ovl_min = '0;
      sum_ovl_max = '0;
      sum_pri_min = '0;
      sum_pri_max = '0;
      sum_out     = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Presents one case request, idling first at the sender's rate, and waits
  // for the edge that takes it. Valid stays high on exit so back-to-back
  // requests never drop it within one time step.
  task automatic send_case(input ftic_pkg::ftic_in_t c);
    bit                  produced;
    ftic_pkg::ftic_out_t r;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (in_stall);
    accumulate_case(c, produced, r);
    if (produced) expected_ratios.push_back(r);
  endtask

  // Stops sending, lets every expected result come out, then leaves room for
  // a case or divide that produces nothing visible to finish.
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_ratios.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; the strobe drops for a cycle so consecutive writes
  // never lower and raise it in the same step.
  task automatic write_reg(input logic [ftic_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ftic_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      ftic_pkg::CFG_TERM_LEVELS:   cur_levels    = val;
      ftic_pkg::CFG_FUZZY_COLUMNS: cur_fuzzy     = val[ftic_pkg::MAX_COLS-1:0];
      ftic_pkg::CFG_NECESSITY:     cur_necessity = val[0];
      default: ;
    endcase
  endtask

  function automatic ftic_pkg::ftic_in_t make_case(input logic [ftic_pkg::VAL_W-1:0] fill,
                                                   input logic [ftic_pkg::VAL_W-1:0] om,
                                                   input logic last);
    ftic_pkg::ftic_in_t c;
    c.case_value_0       = fill;
    c.case_value_1       = fill;
    c.case_value_2       = fill;
    c.case_value_3       = fill;
    c.case_value_4       = fill;
    c.case_value_5       = fill;
    c.case_value_6       = fill;
    c.case_value_7       = fill;
    c.outcome_membership = om;
    c.last_case          = last;
    return c;
  endfunction

  // Random case shaped by the current term: crisp columns hit their category
  // about half the time, fuzzy columns mix extremes, in-range and over-range.
  function automatic ftic_pkg::ftic_in_t rand_case(input logic last);
    logic [ftic_pkg::VAL_W-1:0] vals [ftic_pkg::MAX_COLS];
    logic [ftic_pkg::LVL_W-1:0] lvl;
    ftic_pkg::ftic_in_t         c;
    for (int j = 0; j < ftic_pkg::MAX_COLS; j++) begin
      lvl = cur_levels[ftic_pkg::LVL_W*j +: ftic_pkg::LVL_W];
      if (!cur_fuzzy[j] && lvl != '0 && $urandom_range(1) == 1) begin
        vals[j] = ftic_pkg::VAL_W'(lvl - 1);
      end else begin
        case ($urandom_range(5))
          0:       vals[j] = '0;
          1:       vals[j] = ftic_pkg::ONE;
          2:       vals[j] = ftic_pkg::VAL_W'($urandom);
          3:       vals[j] = ftic_pkg::VAL_W'($urandom_range(15));
          default: vals[j] = ftic_pkg::VAL_W'($urandom_range(32768));
        endcase
      end
    end
    c = make_case('0, '0, last);
    c.case_value_0 = vals[0];
    c.case_value_1 = vals[1];
    c.case_value_2 = vals[2];
    c.case_value_3 = vals[3];
    c.case_value_4 = vals[4];
    c.case_value_5 = vals[5];
    c.case_value_6 = vals[6];
    c.case_value_7 = vals[7];
    case ($urandom_range(9))
      0:       c.outcome_membership = '0;
      1:       c.outcome_membership = ftic_pkg::ONE;
      2:       c.outcome_membership = ftic_pkg::VAL_W'($urandom);
      default: c.outcome_membership = ftic_pkg::VAL_W'($urandom_range(32768));
    endcase
    return c;
  endfunction

  // New term, column kinds and PRI mode, extremes included now and then.
  task automatic randomize_config();
    logic [ftic_pkg::CFG_W-1:0]    levels;
    logic [ftic_pkg::MAX_COLS-1:0] fuzzy;
    int                            pick;
    for (int j = 0; j < ftic_pkg::MAX_COLS; j++) begin
      pick = $urandom_range(9);
      if (pick < 3) begin
        levels[ftic_pkg::LVL_W*j +: ftic_pkg::LVL_W] = '0;
      end else if (pick < 6) begin
        levels[ftic_pkg::LVL_W*j +: ftic_pkg::LVL_W] = 4'd1;
      end else begin
        levels[ftic_pkg::LVL_W*j +: ftic_pkg::LVL_W] =
          ftic_pkg::LVL_W'($urandom_range(2, 15));
      end
    end
    pick = $urandom_range(19);
    if (pick == 0)      levels = '0;
    else if (pick < 3)  levels = '1;
    case ($urandom_range(5))
      0:       fuzzy = '0;
      1:       fuzzy = '1;
      default: fuzzy = ftic_pkg::MAX_COLS'($urandom);
    endcase
    write_reg(ftic_pkg::CFG_TERM_LEVELS, levels);
    write_reg(ftic_pkg::CFG_FUZZY_COLUMNS, ftic_pkg::CFG_W'(fuzzy));
    write_reg(ftic_pkg::CFG_NECESSITY, ftic_pkg::CFG_W'($urandom_range(1)));
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [ftic_pkg::VAL_W-1:0] got,
                             input logic [ftic_pkg::VAL_W-1:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, exp_val));
  endtask

  // Takes result requests and randomizes the stall for the next edge. Values
  // read here are the ones present just before this edge.
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (expected_ratios.size() == 0) begin
        report_mismatch("result request with no case closed");
      end else begin
        want = expected_ratios.pop_front();
        check_field("inclusion_of_min", out_data.inclusion_of_min, want.inclusion_of_min);
        check_field("coverage_of_min", out_data.coverage_of_min, want.coverage_of_min);
        check_field("inclusion_of_max", out_data.inclusion_of_max, want.inclusion_of_max);
        check_field("coverage_of_max", out_data.coverage_of_max, want.coverage_of_max);
        check_field("pri_of_min", out_data.pri_of_min, want.pri_of_min);
        check_field("pri_of_max", out_data.pri_of_max, want.pri_of_max);
        check_field("empty_term", ftic_pkg::VAL_W'(out_data.empty_term),
                    ftic_pkg::VAL_W'(want.empty_term));
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset leaves every level at zero: the term is empty.
  task automatic test_empty_term();
    send_case(make_case(16'hFFFF, ftic_pkg::ONE, 1'b0));
    send_case(make_case(16'h0000, 16'h0000, 1'b1));
  endtask

  // All columns fuzzy; complemented at level 1, plain at level 15; values at
  // 0, 1.0 and above 1.0, outcome likewise.
  task automatic test_fuzzy_extremes();
    ftic_pkg::ftic_in_t c;
    settle_block();
    write_reg(ftic_pkg::CFG_TERM_LEVELS, 32'h1111_1111);
    write_reg(ftic_pkg::CFG_FUZZY_COLUMNS, 32'h0000_00FF);
    write_reg(ftic_pkg::CFG_NECESSITY, 32'h0);
    send_case(make_case(16'h0000, ftic_pkg::ONE, 1'b0));
    send_case(make_case(16'hFFFF, 16'h0000, 1'b0));
    send_case(make_case(ftic_pkg::ONE, 16'hFFFF, 1'b1));
    settle_block();
    write_reg(ftic_pkg::CFG_TERM_LEVELS, 32'hFFFF_FFFF);
    c = make_case(16'h4000, 16'h4000, 1'b0);
    c.case_value_0 = 16'h0000;
    c.case_value_7 = 16'hFFFF;
    send_case(c);
    send_case(make_case(16'h7FFF, 16'h8001, 1'b1));
  endtask

  // Crisp columns: a match gives 1.0, a miss or a huge category gives 0.
  // Ends with a term that never matches and a zero outcome: all ratios 0/0.
  task automatic test_crisp_categories();
    ftic_pkg::ftic_in_t c;
    settle_block();
    write_reg(ftic_pkg::CFG_FUZZY_COLUMNS, 32'h0);
    write_reg(ftic_pkg::CFG_TERM_LEVELS, 32'h0000_00F3);
    c = make_case(16'h0000, 16'h6000, 1'b0);
    c.case_value_0 = 16'd2;
    c.case_value_1 = 16'd14;
    send_case(c);
    c.case_value_1 = 16'd0;
    send_case(c);
    send_case(make_case(16'hFFFF, ftic_pkg::ONE, 1'b1));
    settle_block();
    write_reg(ftic_pkg::CFG_TERM_LEVELS, 32'h0000_0001);
    send_case(make_case(16'd5, 16'h0000, 1'b1));
  endtask

  // Necessity variant of PRI with one complemented and one plain fuzzy column.
  task automatic test_necessity_pri();
    ftic_pkg::ftic_in_t c;
    settle_block();
    write_reg(ftic_pkg::CFG_NECESSITY, 32'h1);
    write_reg(ftic_pkg::CFG_FUZZY_COLUMNS, 32'h0000_0003);
    write_reg(ftic_pkg::CFG_TERM_LEVELS, 32'h0000_0021);
    c = make_case(16'h0000, 16'h5000, 1'b0);
    c.case_value_0 = 16'h2000;
    c.case_value_1 = 16'h6000;
    send_case(c);
    c.case_value_0 = 16'h7000;
    c.case_value_1 = 16'h1000;
    c.outcome_membership = 16'h7FFF;
    send_case(c);
    send_case(make_case(ftic_pkg::ONE, ftic_pkg::ONE, 1'b1));
  endtask

  // A write to the undecoded index must not disturb any register.
  task automatic test_unknown_index();
    settle_block();
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    send_case(rand_case(1'b1));
  endtask

  // Levels cleared between the cases of one data set: the flag follows the
  // levels seen by the last case.
  task automatic test_midrun_write();
    settle_block();
    write_reg(ftic_pkg::CFG_NECESSITY, 32'h0);
    write_reg(ftic_pkg::CFG_FUZZY_COLUMNS, 32'h0000_0001);
    write_reg(ftic_pkg::CFG_TERM_LEVELS, 32'h0000_0002);
    send_case(make_case(16'h3000, 16'h2000, 1'b0));
    settle_block();
    write_reg(ftic_pkg::CFG_TERM_LEVELS, 32'h0);
    send_case(make_case(16'h3000, 16'h2000, 1'b1));
  endtask

  // Random data sets under one idling profile; the config changes every few
  // sets, and now and then the sender holds off until all results are back.
  task automatic test_random_datasets(input int idle_pct, input int hold_pct,
                                      input int n_items);
    int sent;
    int len;
    int sets;
    settle_block();
    sender_idle_pct = idle_pct;
    stall_pct       = hold_pct;
    sent            = 0;
    while (sent < n_items) begin
      settle_block();
      randomize_config();
      sets = $urandom_range(3, 8);
      repeat (sets) begin
        len = ($urandom_range(99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 40);
        for (int k = 1; k <= len; k++) send_case(rand_case(k == len));
        sent += len;
        if ($urandom_range(7) == 0) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (expected_ratios.size() != 0) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_term();
    test_fuzzy_extremes();
    test_crisp_categories();
    test_necessity_pri();
    test_unknown_index();
    test_midrun_write();

    test_random_datasets(0, 0, 330);
    test_random_datasets(75, 0, 330);
    test_random_datasets(0, 75, 330);
    test_random_datasets(26, 26, 330);

    settle_block();
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
